// ===== rtl/ipcmb_pkg.sv =====
package ipcmb_pkg;

    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int CTRL_W = 6;

    localparam logic [CTRL_W-1:0] CTRL_WRITABLE = 6'h39;

    localparam int CTRL_EXECUTE_BIT  = 0;
    localparam int CTRL_ACK_BIT      = 1;
    localparam int CTRL_DONE_BIT     = 2;
    localparam int CTRL_RELAUNCH_BIT = 3;
    localparam int CTRL_DONE_IE_BIT  = 4;
    localparam int CTRL_ACK_IE_BIT   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_CTRL  = 3'd0,
        FUNC_WR_MSG   = 3'd1,
        FUNC_RD_CTRL  = 3'd2,
        FUNC_RD_REPLY = 3'd3,
        FUNC_ACK_EVT  = 3'd4,
        FUNC_DONE_EVT = 3'd5
    } func_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_request;
        logic              execute_request;
        logic [DATA_W-1:0] execute_message;
        logic              relaunch_request;
    } rsp_t;

    function automatic logic irq_line(input logic [CTRL_W-1:0] ctrl);
        irq_line = (ctrl[CTRL_DONE_BIT] & ctrl[CTRL_DONE_IE_BIT])
                 | (ctrl[CTRL_ACK_BIT] & ctrl[CTRL_ACK_IE_BIT]);
    endfunction

endpackage

// ===== rtl/ipcmb_if.sv =====
interface ipcmb_req_if
    import ipcmb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] data;

    modport source (output valid, output func, output data, input ready);
    modport sink   (input valid, input func, input data, output ready);
endinterface

interface ipcmb_rsp_if
    import ipcmb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_request;
    logic              execute_request;
    logic [DATA_W-1:0] execute_message;
    logic              relaunch_request;

    modport source (output valid, output read_data, output irq_request,
                    output execute_request, output execute_message,
                    output relaunch_request, input ready);
    modport sink   (input valid, input read_data, input irq_request,
                    input execute_request, input execute_message,
                    input relaunch_request, output ready);
endinterface

// ===== rtl/ipc_mailbox_control_regs.sv =====
// Mailbox register block between two processors.
// Channel req carries one transaction per bus access or event: func selects
// a control write, message write, control read, reply read, acknowledge
// event or completed event; data carries write data.
// Channel rsp returns exactly one transaction per req transaction, in order:
// read data, the interrupt request level after a control write or event,
// and the execute and relaunch requests raised by a control write.
// The input register takes the req transaction on acceptance, the result
// register takes its result when rsp is not stalled, and rsp valid is high
// from then on. Throughput is one transaction per cycle while rsp is not
// stalled, set by the single update pass over the control word and the two
// message registers.
// Reset clears the control word, both messages and all valid flags.
// When rsp is stalled, the result register holds and the input register
// takes one more transaction; req.ready then drops until rsp moves.
module ipc_mailbox_control_regs
    import ipcmb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ipcmb_req_if.sink   req,
    ipcmb_rsp_if.source rsp
);

    logic              s1_valid_reg;
    logic [FUNC_W-1:0] s1_func_reg;
    logic [DATA_W-1:0] s1_data_reg;

    logic              out_valid_reg;
    rsp_t              out_reg;
    rsp_t              out_next;

    logic [CTRL_W-1:0] ctrl_reg;
    logic [CTRL_W-1:0] ctrl_next;
    logic [DATA_W-1:0] msg_reg;
    logic [DATA_W-1:0] msg_next;
    logic [DATA_W-1:0] reply_reg;
    logic [DATA_W-1:0] reply_next;

    logic              advance;
    logic [CTRL_W-1:0] wr_bits;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || advance;
    assign wr_bits   = s1_data_reg[CTRL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg <= req.func;
            s1_data_reg <= req.data;
        end
    end

    always_comb
    begin
        ctrl_next  = ctrl_reg;
        msg_next   = msg_reg;
        reply_next = reply_reg;
        out_next   = '0;
        case (s1_func_reg)
            FUNC_WR_CTRL:
            begin
                out_next.execute_request  = !ctrl_reg[CTRL_EXECUTE_BIT]
                                            && wr_bits[CTRL_EXECUTE_BIT];
                out_next.execute_message  = out_next.execute_request ? msg_reg : '0;
                out_next.relaunch_request = !ctrl_reg[CTRL_RELAUNCH_BIT]
                                            && wr_bits[CTRL_RELAUNCH_BIT];
                ctrl_next = (ctrl_reg & ~CTRL_WRITABLE) | (wr_bits & CTRL_WRITABLE);
                if (wr_bits[CTRL_ACK_BIT])
                begin
                    ctrl_next[CTRL_ACK_BIT] = 1'b0;
                end
                if (wr_bits[CTRL_DONE_BIT])
                begin
                    ctrl_next[CTRL_DONE_BIT] = 1'b0;
                end
                out_next.irq_request = irq_line(ctrl_next);
            end
            FUNC_WR_MSG:
            begin
                msg_next = s1_data_reg;
            end
            FUNC_RD_CTRL:
            begin
                out_next.read_data = {{(DATA_W-CTRL_W){1'b0}}, ctrl_reg};
            end
            FUNC_RD_REPLY:
            begin
                out_next.read_data = reply_reg;
            end
            FUNC_ACK_EVT:
            begin
                ctrl_next[CTRL_ACK_BIT] = 1'b1;
                out_next.irq_request    = irq_line(ctrl_next);
            end
            FUNC_DONE_EVT:
            begin
                ctrl_next[CTRL_DONE_BIT] = 1'b1;
                reply_next               = msg_reg;
                out_next.irq_request     = irq_line(ctrl_next);
            end
            default:
            begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            msg_reg       <= '0;
            reply_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                ctrl_reg  <= ctrl_next;
                msg_reg   <= msg_next;
                reply_reg <= reply_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.read_data        = out_reg.read_data;
    assign rsp.irq_request      = out_reg.irq_request;
    assign rsp.execute_request  = out_reg.execute_request;
    assign rsp.execute_message  = out_reg.execute_message;
    assign rsp.relaunch_request = out_reg.relaunch_request;

endmodule

// ===== rtl/ipcmb_checker.sv =====
module ipcmb_checker
    import ipcmb_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [DATA_W-1:0] read_data,
    input logic              irq_request,
    input logic              execute_request,
    input logic [DATA_W-1:0] execute_message,
    input logic              relaunch_request
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp transaction dropped while stalled");

    a_msg_only_with_exec: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !execute_request |-> execute_message == '0)
        else $error("execute message without execute request");

    a_read_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && read_data != '0 |-> !irq_request && !execute_request
                                          && !relaunch_request)
        else $error("read data together with request flags");

endmodule

bind ipc_mailbox_control_regs ipcmb_checker u_ipcmb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .read_data        (rsp.read_data),
    .irq_request      (rsp.irq_request),
    .execute_request  (rsp.execute_request),
    .execute_message  (rsp.execute_message),
    .relaunch_request (rsp.relaunch_request)
);
